/* rtl/core/pru_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

	localparam int PERM_N       = 8;
	localparam int ELEM_W       = 3;
	localparam int IDX_W        = 16;
	localparam int LEN_W        = 4;
	localparam int MAX_ELEMENTS = 8;

	typedef logic [ELEM_W-1:0]             elem_t;
	typedef logic [PERM_N-1:0][ELEM_W-1:0] perm_t;
	typedef logic [IDX_W-1:0]              idx_t;

	// word in flight through the rebuild steps
	typedef struct packed {
		logic  cmd;
		logic  inval;
		idx_t  index;
		perm_t q;
		perm_t d;
	} pkt_t;

	localparam logic CMD_RANK   = 1'b0;
	localparam logic CMD_UNRANK = 1'b1;

	function automatic int unsigned pru_fact(input int unsigned k);
		int unsigned f;
		f = 1;
		for (int unsigned i = 2; i <= k; i++) begin
			f = f * i;
		end
		return f;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/pru_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

// lane m: rank term cnt*m! and quotient floor(idx / m!)
module pru_lane import pru_pkg::*; #(
	parameter int LANE = 0
) (
	input  wire logic  clk,
	input  wire logic  ld2,
	input  wire logic  ld3,
	input  wire perm_t perm_s1,
	input  wire idx_t  idx_s1,
	input  wire idx_t  idx_s2,
	output idx_t       term_s3,
	output idx_t       quot_s3
);

	localparam int unsigned FACT  = pru_fact(LANE);
	localparam logic [16:0] DIV   = 17'(FACT);
	localparam logic [16:0] RECIP = 17'((1 << 16) / FACT);

	elem_t       own;
	logic [2:0]  cnt;
	logic [32:0] prod;
	logic [32:0] qd;
	logic [16:0] rem;
	idx_t        term_s2;
	idx_t        qe_s2;

	generate
		if (LANE < PERM_N) begin : g_own
			assign own = perm_s1[LANE];
		end else begin : g_none
			assign own = '0;
		end
	endgenerate

	always_comb begin
		cnt = '0;
		for (int j = 0; j < PERM_N; j++) begin
			if (j < LANE && own > perm_s1[j]) begin
				cnt = cnt + 3'd1;
			end
		end
	end

	assign prod = 33'(idx_s1) * 33'(RECIP);

	always_ff @(posedge clk) begin
		if (ld2) begin
			term_s2 <= IDX_W'(32'(cnt) * FACT);
			qe_s2   <= prod[31:16];
		end
	end

	// estimate is low by at most one
	assign qd  = 33'(qe_s2) * 33'(DIV);
	assign rem = {1'b0, idx_s2} - qd[16:0];

	always_ff @(posedge clk) begin
		if (ld3) begin
			term_s3 <= term_s2;
			quot_s3 <= (rem >= DIV) ? qe_s2 + 16'd1 : qe_s2;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pru_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

// digits from adjacent quotients, rank sum over lane terms
module pru_merge import pru_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    ld4,
	input  wire logic                    ld5,
	input  wire logic                    cmd_s3,
	input  wire logic [LEN_W-1:0]        nlen,
	input  wire idx_t [PERM_N:0]         quot_s3,
	input  wire idx_t [PERM_N-1:0]       term_s3,
	output pkt_t                         pkt_s5
);

	perm_t           dig;
	idx_t            diff [PERM_N];
	logic            cmd_s4;
	logic            inval_s4;
	perm_t           d_s4;
	idx_t [3:0]      psum_s4;

	always_comb begin
		for (int m = 0; m < PERM_N; m++) begin
			diff[m] = quot_s3[m] - IDX_W'(32'(quot_s3[m+1]) * 32'(m + 1));
			dig[m]  = diff[m][ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			cmd_s4   <= cmd_s3;
			inval_s4 <= (quot_s3[nlen] != '0);
			d_s4     <= dig;
			for (int k = 0; k < 4; k++) begin
				psum_s4[k] <= term_s3[2*k] + term_s3[2*k+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld5) begin
			pkt_s5.cmd   <= cmd_s4;
			pkt_s5.inval <= inval_s4;
			pkt_s5.index <= (psum_s4[0] + psum_s4[1]) + (psum_s4[2] + psum_s4[3]);
			pkt_s5.q     <= '0;
			pkt_s5.d     <= d_s4;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pru_step.sv */
`timescale 1ns / 1ps
`default_nettype none

// place digit M, bump earlier-placed elements not below it
module pru_step import pru_pkg::*; #(
	parameter int M = 1
) (
	input  wire logic             clk,
	input  wire logic             ld,
	input  wire logic [LEN_W-1:0] nlen,
	input  wire pkt_t             pkt_in,
	output pkt_t                  pkt_s1
);

	pkt_t nxt;

	always_comb begin
		nxt = pkt_in;
		if (LEN_W'(M) < nlen) begin
			for (int j = 0; j < M; j++) begin
				if (pkt_in.d[M] <= pkt_in.q[j]) begin
					nxt.q[j] = pkt_in.q[j] + 3'd1;
				end
			end
			nxt.q[M] = pkt_in.d[M];
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			pkt_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/permutation_rank_unrank.sv */
// Throughput: one word per cycle; the depth is set by the MAX_ELEMENTS - 1 rebuild steps.
// Each stage holds its word under back-pressure and takes a new one once it moves on.
// Reset (arst_n low): all stages empty, no output word, perm_length back to 8.
`timescale 1ns / 1ps
`default_nettype none

module permutation_rank_unrank import pru_pkg::*; #(
	parameter int MAX_ELEMENTS = pru_pkg::MAX_ELEMENTS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [LEN_W-1:0] cfg_wdata,    // perm_length
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [39:0]      s_tdata,      // perm_in_0..perm_in_7, index_in
	input  wire logic             s_tuser,      // command
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [39:0]           m_tdata,      // index_out, perm_out_0..perm_out_7
	output logic                  m_tuser       // index_invalid
);

	localparam int              NSTG = MAX_ELEMENTS + 5;
	localparam logic [LEN_W-1:0] NMAX = LEN_W'(MAX_ELEMENTS);

	logic [LEN_W-1:0]     perm_length_q;
	logic [LEN_W-1:0]     nlen;
	logic [NSTG:1]        vld_q;
	logic [NSTG:1]        rdy;
	logic [NSTG:1]        vin;

	perm_t                pin;
	perm_t                rr;
	logic [LEN_W-1:0]     pos [PERM_N];

	logic                 cmd_s1;
	perm_t                rr_s1;
	idx_t                 idx_s1;
	logic                 cmd_s2;
	idx_t                 idx_s2;
	logic                 cmd_s3;

	idx_t [PERM_N:0]      quot_s3;
	idx_t [PERM_N-1:0]    term_s3;
	pkt_t                 chain [MAX_ELEMENTS];
	pkt_t                 fin;

	perm_t                pout;
	logic [LEN_W-1:0]     opos [PERM_N];
	logic [39:0]          data_q;
	logic                 user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_length_q <= LEN_W'(8);
		end else if (cfg_we) begin
			perm_length_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (perm_length_q < LEN_W'(2)) begin
			nlen = LEN_W'(2);
		end else if (perm_length_q > NMAX) begin
			nlen = NMAX;
		end else begin
			nlen = perm_length_q;
		end
	end

	// stage handshake
	assign vin = {vld_q[NSTG-1:1], s_tvalid};

	always_comb begin
		rdy[NSTG] = !vld_q[NSTG] || m_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	assign s_tready = rdy[1];
	assign m_tvalid = vld_q[NSTG];

	// stage 1: reorder so element m counts from the end
	assign pin = s_tdata[PERM_N*ELEM_W-1:0];

	always_comb begin
		for (int m = 0; m < PERM_N; m++) begin
			pos[m] = nlen - LEN_W'(m) - LEN_W'(1);
			rr[m]  = (LEN_W'(m) < nlen) ? pin[pos[m][ELEM_W-1:0]] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			cmd_s1 <= s_tuser;
			rr_s1  <= rr;
			idx_s1 <= s_tdata[39:24];
		end
		if (rdy[2]) begin
			cmd_s2 <= cmd_s1;
			idx_s2 <= idx_s1;
		end
		if (rdy[3]) begin
			cmd_s3 <= cmd_s2;
		end
	end

	// stages 2-3: lanes
	generate
		for (genvar m = 0; m <= PERM_N; m++) begin : g_lane
			if (m <= MAX_ELEMENTS) begin : g_on
				idx_t term;
				pru_lane #(
					.LANE(m)
				) u_lane (
					.clk     (clk),
					.ld2     (rdy[2]),
					.ld3     (rdy[3]),
					.perm_s1 (rr_s1),
					.idx_s1  (idx_s1),
					.idx_s2  (idx_s2),
					.term_s3 (term),
					.quot_s3 (quot_s3[m])
				);
				if (m < PERM_N) begin : g_term
					assign term_s3[m] = term;
				end
			end else begin : g_off
				assign quot_s3[m] = '0;
				if (m < PERM_N) begin : g_term
					assign term_s3[m] = '0;
				end
			end
		end
	endgenerate

	// stages 4-5
	pru_merge u_merge (
		.clk     (clk),
		.ld4     (rdy[4]),
		.ld5     (rdy[5]),
		.cmd_s3  (cmd_s3),
		.nlen    (nlen),
		.quot_s3 (quot_s3),
		.term_s3 (term_s3),
		.pkt_s5  (chain[0])
	);

	// rebuild steps, stages 6 .. MAX_ELEMENTS + 4
	generate
		for (genvar s = 1; s < MAX_ELEMENTS; s++) begin : g_step
			pru_step #(
				.M(s)
			) u_step (
				.clk    (clk),
				.ld     (rdy[5+s]),
				.nlen   (nlen),
				.pkt_in (chain[s-1]),
				.pkt_s1 (chain[s])
			);
		end
	endgenerate

	assign fin = chain[MAX_ELEMENTS-1];

	// output stage
	always_comb begin
		for (int i = 0; i < PERM_N; i++) begin
			opos[i] = nlen - LEN_W'(i) - LEN_W'(1);
			pout[i] = (fin.cmd == CMD_UNRANK && LEN_W'(i) < nlen) ?
				fin.q[opos[i][ELEM_W-1:0]] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NSTG]) begin
			data_q <= {pout, (fin.cmd == CMD_RANK) ? fin.index : '0};
			user_q <= (fin.cmd == CMD_UNRANK) && fin.inval;
		end
	end

	assign m_tdata = data_q;
	assign m_tuser = user_q;

endmodule

`default_nettype wire
